// ----- rtl/swg_pkg.sv -----
// Package for the source wavelet generator: shape codes, register indexes,
// fixed-point constants and the exp factor table. No dependencies.
package swg_pkg;

	localparam logic [1:0] SHAPE_GAUSS = 2'd0;
	localparam logic [1:0] SHAPE_DERIV = 2'd1;
	localparam logic [1:0] SHAPE_RICKER = 2'd2;
	localparam logic [1:0] SHAPE_STEP = 2'd3;

	localparam logic [1:0] REG_SHAPE = 2'd0;
	localparam logic [1:0] REG_DELAY = 2'd1;
	localparam logic [1:0] REG_PERIOD = 2'd2;
	localparam logic [1:0] REG_FREQ = 2'd3;

	localparam logic [31:0] PI_Q30 = 32'd3373259426;
	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
	localparam int EXP_STEPS = 24;

	// floor square root, bit by bit
	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] n, r, b;
		n = v;
		r = '0;
		b = 64'd1 << 62;
		for (int j = 0; j < 32; j++) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// 2^(-2^-i) in Q1.30, i = 1..24: successive floor square roots, starting
	// from sqrt(0.5); entry 0 is one. Evaluated at elaboration.
	function automatic logic [30:0] exp_rom(input int i);
		logic [63:0] r;
		r = 64'(ONE_Q30);
		for (int j = 1; j <= EXP_STEPS; j++) begin
			if (j <= i)
				r = isqrt64((j == 1) ? (64'd1 << 59) : (r << 30));
		end
		return r[30:0];
	endfunction

	// Magnitude and sign down to a saturated 32-bit two's complement word
	function automatic logic [31:0] sat32(input logic [63:0] m, input logic neg);
		logic [31:0] r;
		if (!neg)
			r = (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
		else if (m >= 64'h8000_0000)
			r = 32'h8000_0000;
		else
			r = 32'd0 - m[31:0];
		return r;
	endfunction

endpackage

// ----- rtl/source_wavelet_generator.sv -----
// Source wavelet generator: step index to source time function sample.
// The start beat runs through stages s1 to s5, the exp unit, f1 and f2 to the
// done strobe. Throughput: one step per cycle, set by the pipelined exp unit (one table multiply a stage).
// Reset: registers take shape Ricker, t0 0, dt 16777, f0 2560; pipeline empties.
// Results are strobed on done for one cycle; the receiver cannot stall.
// Uses swg_pkg and swg_exp.
module source_wavelet_generator #(
	parameter int STEP_BITS = 24,
	parameter int TIME_FRAC_BITS = 24,
	parameter int OUT_FRAC_BITS = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [23:0] step_index,
	output logic        done,
	output logic signed [31:0] wavelet_value,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);

	localparam int SHV = TIME_FRAC_BITS - 16;
	localparam int TAG_W = 2 + 1 + 1 + 1 + 29 + 1;

	logic [1:0]  shape_q;
	logic [31:0] delay_q;
	logic [31:0] period_q;
	logic [15:0] freq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_q <= swg_pkg::SHAPE_RICKER;
			delay_q <= 32'd0;
			period_q <= 32'd16777;
			freq_q <= 16'd2560;
		end else if (cfg_we) begin
			case (cfg_index)
				swg_pkg::REG_SHAPE: shape_q <= cfg_wdata[1:0];
				swg_pkg::REG_DELAY: delay_q <= cfg_wdata;
				swg_pkg::REG_PERIOD: period_q <= cfg_wdata;
				swg_pkg::REG_FREQ: freq_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// w = pi*f0 in Q.24, used by the derivative shape
	logic [47:0] wp;
	logic [33:0] w_q;
	assign wp = 48'(freq_q) * 48'(swg_pkg::PI_Q30);
	always_ff @(posedge clk) begin
		w_q <= wp[47:14];
	end

	// s1: step*dt plus half dt
	logic        v_s1;
	logic [63:0] t_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start;
	end
	always_ff @(posedge clk) begin
		t_s1 <= 64'(step_index[STEP_BITS-1:0]) * 64'(period_q) + 64'(period_q >> 1);
	end

	// s2: saturate, |tau|
	logic        v_s2, late_s2, early_s2;
	logic [31:0] atau_s2;
	logic [31:0] tsat;
	assign tsat = (t_s1 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t_s1[31:0];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		late_s2 <= tsat > delay_q;
		early_s2 <= tsat < delay_q;
		atau_s2 <= (tsat > delay_q) ? tsat - delay_q : delay_q - tsat;
	end

	// s3: u = f0*|tau|, v
	logic        v_s3, late_s3, early_s3;
	logic [47:0] vv_s3;
	logic [47:0] u;
	assign u = 48'(freq_q) * 48'(atau_s2);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		late_s3 <= late_s2;
		early_s3 <= early_s2;
		vv_s3 <= u >> SHV;
	end

	// s4: x = v*pi
	logic        v_s4, late_s4, early_s4, cap_s4;
	logic [63:0] xp_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		late_s4 <= late_s3;
		early_s4 <= early_s3;
		cap_s4 <= vv_s3[47:32] != 16'd0;
		xp_s4 <= 64'(vv_s3[31:0]) * 64'(swg_pkg::PI_Q30);
	end

	// s5: cap test, z = x*x
	logic [33:0] xw;
	logic        cap5;
	assign xw = xp_s4[63:30];
	assign cap5 = cap_s4 || (xw >= 34'h1000_0000);
	logic        v_s5, late_s5, early_s5, cap_s5;
	logic [28:0] x_s5;
	logic [31:0] z_s5;
	logic [55:0] zz;
	assign zz = 56'(xw[27:0]) * 56'(xw[27:0]);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		late_s5 <= late_s4;
		early_s5 <= early_s4;
		cap_s5 <= cap5;
		x_s5 <= cap5 ? 29'h1000_0000 : 29'(xw[27:0]);
		z_s5 <= zz[55:24];
	end

	// exp argument: z, or 2z for the derivative
	logic        ecap;
	logic [31:0] ez;
	always_comb begin
		if (shape_q == swg_pkg::SHAPE_DERIV) begin
			ecap = cap_s5 || z_s5[31];
			ez = {z_s5[30:0], 1'b0};
		end else begin
			ecap = cap_s5;
			ez = z_s5;
		end
	end

	logic [TAG_W-1:0] tag_in, tag_out;
	assign tag_in = {shape_q, late_s5, early_s5, cap_s5, x_s5,
		z_s5 >= 32'h0080_0001 ? 1'b1 : 1'b0};

	// 2z - 1 and 1 - 2z magnitude, Q.24, 33 bits
	logic [32:0] rk_s5;
	always_ff @(posedge clk) begin
		rk_s5 <= ({z_s5, 1'b0} > 33'h100_0000) ? {z_s5, 1'b0} - 33'h100_0000
			: 33'h100_0000 - {z_s5, 1'b0};
	end

	logic        ev;
	logic [30:0] ee;
	swg_exp #(.TAG_W(TAG_W)) u_exp (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s5), .in_cap(ecap), .in_z(ez),
		.in_tag(tag_in), .out_valid(ev), .out_e(ee), .out_tag(tag_out)
	);

	// ricker factor delayed through the rk_d chain after rk_s5 to line up with the exp output
	localparam int RD = 26;
	logic [32:0] rk_d [0:RD];
	assign rk_d[0] = rk_s5;
	for (genvar i = 1; i <= RD; i++) begin : g_rk
		always_ff @(posedge clk) rk_d[i] <= rk_d[i-1];
	end

	logic [1:0]  sh_e;
	logic        late_e, early_e, cap_e, rneg_e;
	logic [28:0] x_e;
	assign sh_e = tag_out[TAG_W-1 -: 2];
	assign late_e = tag_out[TAG_W-3];
	assign early_e = tag_out[TAG_W-4];
	assign cap_e = tag_out[TAG_W-5];
	assign x_e = tag_out[TAG_W-6 -: 29];
	assign rneg_e = tag_out[0];

	// f1: products of exp with x or the Ricker factor
	logic        v_f1, late_f1, early_f1, cap_f1, rneg_f1;
	logic [1:0]  sh_f1;
	logic [30:0] e_f1;
	logic [59:0] q_f1;
	logic [63:0] rp_f1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_f1 <= 1'b0;
		else v_f1 <= ev;
	end
	always_ff @(posedge clk) begin
		sh_f1 <= sh_e;
		late_f1 <= late_e;
		early_f1 <= early_e;
		cap_f1 <= cap_e;
		rneg_f1 <= rneg_e;
		e_f1 <= ee;
		q_f1 <= 60'(x_e) * 60'(ee);
		rp_f1 <= 64'(rk_d[RD]) * 64'(ee);
	end

	// f2: 4*w*q
	logic        v_f2, late_f2, early_f2, cap_f2, rneg_f2;
	logic [1:0]  sh_f2;
	logic [30:0] e_f2;
	logic [63:0] rp_f2, m_f2;
	logic [29:0] qq;
	assign qq = q_f1[59:30];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_f2 <= 1'b0;
		else v_f2 <= v_f1;
	end
	always_ff @(posedge clk) begin
		sh_f2 <= sh_f1;
		late_f2 <= late_f1;
		early_f2 <= early_f1;
		cap_f2 <= cap_f1;
		rneg_f2 <= rneg_f1;
		e_f2 <= e_f1;
		rp_f2 <= rp_f1;
		m_f2 <= (64'(w_q) * 64'(qq)) << 2;
	end

	// f3: select and saturate
	logic [31:0] res;
	always_comb begin
		case (sh_f2)
			swg_pkg::SHAPE_GAUSS:
				res = swg_pkg::sat32(64'(e_f2) >> (30 - OUT_FRAC_BITS), 1'b0);
			swg_pkg::SHAPE_DERIV:
				res = swg_pkg::sat32(m_f2 >> (48 - OUT_FRAC_BITS), early_f2);
			swg_pkg::SHAPE_RICKER:
				res = cap_f2 ? 32'd0
					: swg_pkg::sat32(rp_f2 >> (54 - OUT_FRAC_BITS), rneg_f2);
			default:
				res = late_f2 ? 32'(64'd1 << OUT_FRAC_BITS) : 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= v_f2;
	end
	always_ff @(posedge clk) begin
		wavelet_value <= res;
	end

endmodule

// ----- rtl/swg_exp.sv -----
// Pipelined exp(-z), z in Q.24 (32 bits plus an overflow flag), result Q1.30.
// One table multiply per stage, 24 stages, two front stages and an output
// register. Uses swg_pkg.
module swg_exp #(
	parameter int TAG_W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_cap,
	input  logic [31:0]      in_z,
	input  logic [TAG_W-1:0] in_tag,
	output logic             out_valid,
	output logic [30:0]      out_e,
	output logic [TAG_W-1:0] out_tag
);

	localparam int N = swg_pkg::EXP_STEPS;

	// front: y = z*log2e
	logic             v_s1;
	logic             cap_s1;
	logic [62:0]      y_s1;
	logic [TAG_W-1:0] tag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		cap_s1 <= in_cap;
		y_s1 <= 63'(in_z) * 63'(swg_pkg::LOG2E_Q30);
		tag_s1 <= in_tag;
	end

	logic [32:0] yq;
	assign yq = y_s1[62:30];

	logic             v_q [0:N];
	logic             zero_q [0:N];
	logic [4:0]       k_q [0:N];
	logic [23:0]      f_q [0:N];
	logic [30:0]      r_q [0:N];
	logic [TAG_W-1:0] tag_q [0:N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q[0] <= 1'b0;
		end else begin
			v_q[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		zero_q[0] <= cap_s1 || (yq[32:24] >= 9'd31);
		k_q[0] <= yq[28:24];
		f_q[0] <= yq[23:0];
		r_q[0] <= swg_pkg::ONE_Q30;
		tag_q[0] <= tag_s1;
	end

	for (genvar i = 1; i <= N; i++) begin : g_stage
		localparam logic [30:0] FACTOR = swg_pkg::exp_rom(i);
		logic [61:0] prod;
		assign prod = 62'(r_q[i-1]) * 62'(FACTOR);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[i] <= 1'b0;
			end else begin
				v_q[i] <= v_q[i-1];
			end
		end
		always_ff @(posedge clk) begin
			zero_q[i] <= zero_q[i-1];
			k_q[i] <= k_q[i-1];
			f_q[i] <= f_q[i-1];
			tag_q[i] <= tag_q[i-1];
			r_q[i] <= f_q[i-1][N-i] ? prod[60:30] : r_q[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_q[N];
		end
	end

	always_ff @(posedge clk) begin
		out_e <= zero_q[N] ? 31'd0 : (r_q[N] >> k_q[N]);
		out_tag <= tag_q[N];
	end

endmodule

// ----- rtl/swg_checker.sv -----
// Port-level checks for the source wavelet generator, bound to the top level.
// Depends only on the top level's port list.
module swg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [31:0] wavelet_value
);

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_done_has_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 35))
		else $error("done without a start beat");
	a_start_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##35 done)
		else $error("start beat lost");
	a_value_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown(wavelet_value))
		else $error("unknown value on a done beat");

endmodule

bind source_wavelet_generator swg_checker u_swg_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.wavelet_value(wavelet_value)
);
